@@ rtl/core/species_time_step_factor_macros.svh @@
// Assertion macros for the species time-step factor block.
// Synthesis sees empty bodies.
`ifndef SPECIES_TIME_STEP_FACTOR_MACROS_SVH
`define SPECIES_TIME_STEP_FACTOR_MACROS_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define STSF_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// antecedent implies consequent a fixed number of cycles later
`define STSF_ASSERT_LAT(label, clk, rst, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error("latency assertion failed");
`else
`define STSF_ASSERT_IMP(label, clk, rst, ante, cons)
`define STSF_ASSERT_LAT(label, clk, rst, ante, n, cons)
`endif

`endif

@@ rtl/core/stsf_pkg.sv @@
`timescale 1ns / 1ps
package stsf_pkg;

  // fixed internal precisions
  localparam int LG_BITS    = 26;
  localparam int WORK_BITS  = 30;
  localparam int POWER_BITS = 16;
  localparam int MANT_BITS  = 23;
  localparam int IP_LIMIT   = 31;
  localparam int SENTINEL_MAG = 1000;

  localparam logic [28:0] LOG10_OF_2_Q30 = 29'd323228497;
  localparam logic [31:0] TINY_PATTERN   = 32'h0DA24260;
  localparam logic [7:0]  EXP_SPECIAL    = 8'hFF;
  localparam logic [9:0]  EXP_BIAS       = 10'd127;

  // configuration register indexes
  typedef logic [1:0] cfg_index_t;
  localparam cfg_index_t CFG_LOWER = 2'd0;
  localparam cfg_index_t CFG_UPPER = 2'd1;
  localparam cfg_index_t CFG_POWER = 2'd2;
  localparam cfg_index_t CFG_RATIO = 2'd3;

  // how t^p is settled for an item
  typedef enum logic [1:0] {
    TP_CALC,
    TP_ZERO,
    TP_FULL
  } tp_code_t;

  // one repeated-squaring step of log2 on a Q1.30 mantissa; returns {bit, x}
  function automatic logic [31:0] lg_step(input logic [30:0] x);
    logic [61:0] sq;
    sq = 62'(x) * 62'(x);
    if (sq[61]) begin
      return {1'b1, sq[61:31]};
    end else begin
      return {1'b0, sq[60:30]};
    end
  endfunction

  // truncating integer square root, elaboration only
  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'd1 << 62;
    for (int it = 0; it < 32; it++) begin
      if (b > v) b = b >> 2;
    end
    for (int it = 0; it < 32; it++) begin
      if (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // 2^(-2^-i) in Q0.30, i from 1
  function automatic logic [29:0] exp_root(input int i);
    logic [63:0] r;
    r = isqrt64(64'd1 << 59);
    for (int j = 1; j < LG_BITS; j++) begin
      if (j < i) r = isqrt64(r << WORK_BITS);
    end
    return r[29:0];
  endfunction

endpackage

@@ rtl/core/species_time_step_factor.sv @@
`timescale 1ns / 1ps
`include "species_time_step_factor_macros.svh"
// Channel  | Signals                              | Handshake
// ---------+--------------------------------------+--------------------------------
// request  | start, busy, mass_fraction           | taken when start && !busy
// result   | done, step_factor                    | one-cycle strobe, no backpressure
// config   | cfg_valid, cfg_ready, cfg_index/data | written when cfg_valid && cfg_ready
//
// Fully pipelined: one request per cycle.
// The pipeline holds two 26-stage log2 squaring chains, a 30-stage restoring
// divider and a 26-stage exp2 product chain; each squaring or exp2 stage holds one multiply.
// busy stays low and cfg_ready high; the result side cannot stall.
// rst (synchronous) clears all valid bits and loads register defaults.
module species_time_step_factor #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [31:0]                 mass_fraction,
  output logic                        done,
  output logic [FRACTION_BITS:0]      step_factor,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  stsf_pkg::cfg_index_t        cfg_index,
  input  logic [FRACTION_BITS+11:0]   cfg_data
);

  localparam int LG    = stsf_pkg::LG_BITS;
  localparam int WB    = stsf_pkg::WORK_BITS;
  localparam int CUT_W = FRACTION_BITS + 12;
  localparam int RAT_W = FRACTION_BITS + 1;
  localparam int DW    = CUT_W + 1;
  localparam int SH    = LG + WB - FRACTION_BITS;
  localparam int NORM_STEPS = 5;
  localparam int LATENCY = (LG + 1) + 3 + (WB + 1) + (NORM_STEPS + 1) + (LG + 1) + 2
                           + (LG + 1) + 3;

  localparam logic signed [CUT_W-1:0] LOWER_RST =
    CUT_W'(-(longint'(20) <<< FRACTION_BITS));
  localparam logic signed [CUT_W-1:0] UPPER_RST =
    CUT_W'(-(longint'(4) <<< FRACTION_BITS));
  localparam logic signed [CUT_W-1:0] SENTINEL_L =
    CUT_W'(-(longint'(stsf_pkg::SENTINEL_MAG) <<< FRACTION_BITS));
  localparam logic [RAT_W-1:0] ONE_R = RAT_W'(1) << FRACTION_BITS;
  localparam logic [30:0] ONE_W = 31'd1 << WB;

  // configuration registers
  logic signed [CUT_W-1:0] lower_cutoff;
  logic signed [CUT_W-1:0] upper_cutoff;
  logic [stsf_pkg::POWER_BITS-1:0] curve_power;
  logic [RAT_W-1:0] step_ratio;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_cutoff <= LOWER_RST;
      upper_cutoff <= UPPER_RST;
      curve_power  <= 16'd8192;
      step_ratio   <= ONE_R;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        stsf_pkg::CFG_LOWER: lower_cutoff <= cfg_data;
        stsf_pkg::CFG_UPPER: upper_cutoff <= cfg_data;
        stsf_pkg::CFG_POWER: curve_power  <= cfg_data[stsf_pkg::POWER_BITS-1:0];
        stsf_pkg::CFG_RATIO: step_ratio   <= cfg_data[RAT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- first log2: mantissa of y ----------------
  logic                 l1_valid [0:LG];
  logic [30:0]          l1_x     [0:LG];
  logic [LG-1:0]        l1_fr    [0:LG];
  logic [7:0]           l1_e     [0:LG];
  logic                 l1_sent  [0:LG];
  stsf_pkg::tp_code_t   l1_code  [0:LG];

  // classify at entry
  always_ff @(posedge clk) begin
    if (rst) begin
      l1_valid[0] <= 1'b0;
    end else begin
      l1_valid[0] <= start && !busy;
    end
    l1_x[0]    <= {1'b1, mass_fraction[stsf_pkg::MANT_BITS-1:0], 7'd0};
    l1_fr[0]   <= '0;
    l1_e[0]    <= mass_fraction[30:23];
    l1_sent[0] <= mass_fraction[31] || (mass_fraction < stsf_pkg::TINY_PATTERN);
    l1_code[0] <= (mass_fraction[30:23] == stsf_pkg::EXP_SPECIAL) ?
                  stsf_pkg::TP_FULL : stsf_pkg::TP_CALC;
  end

  for (genvar i = 0; i < LG; i++) begin : g_lg1
    logic [31:0] step;
    assign step = stsf_pkg::lg_step(l1_x[i]);
    always_ff @(posedge clk) begin
      if (rst) begin
        l1_valid[i+1] <= 1'b0;
      end else begin
        l1_valid[i+1] <= l1_valid[i];
      end
      l1_x[i+1]    <= step[30:0];
      l1_fr[i+1]   <= l1_fr[i] | (LG'(step[31]) << (LG - 1 - i));
      l1_e[i+1]    <= l1_e[i];
      l1_sent[i+1] <= l1_sent[i];
      l1_code[i+1] <= l1_code[i];
    end
  end

  // ---------------- log10 scaling ----------------
  logic               m1_valid, m2_valid, m3_valid;
  logic               m1_neg, m2_neg;
  logic               m1_sent, m2_sent;
  stsf_pkg::tp_code_t m1_code, m2_code, m3_code;
  logic [33:0]        m1_mag;
  logic [45:0]        m2_plo, m2_phi;
  logic signed [CUT_W-1:0] m3_lv;

  logic signed [9:0]  e_unb;
  logic signed [35:0] l2_full;
  logic [62:0]        l10_prod;
  logic [62:0]        l10_round;
  logic [CUT_W-1:0]   l10_mag;

  // log2 = (e - bias) + log2(mantissa), Q.26
  always_comb begin
    e_unb   = signed'({2'b00, l1_e[LG]} - stsf_pkg::EXP_BIAS);
    l2_full = (36'(e_unb) <<< LG) + 36'(l1_fr[LG]);
  end

  // magnitude times log10(2), split in two partial products, then round
  always_comb begin
    l10_prod  = {m2_phi, 17'd0} + 63'(m2_plo);
    l10_round = l10_prod + (63'd1 << (SH - 1));
    l10_mag   = CUT_W'(l10_round >> SH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
      m3_valid <= 1'b0;
    end else begin
      m1_valid <= l1_valid[LG];
      m2_valid <= m1_valid;
      m3_valid <= m2_valid;
    end
    m1_neg  <= l2_full[35];
    m1_mag  <= l2_full[35] ? 34'(-l2_full) : l2_full[33:0];
    m1_sent <= l1_sent[LG];
    m1_code <= l1_code[LG];
    m2_plo  <= 46'(m1_mag[16:0]) * 46'(stsf_pkg::LOG10_OF_2_Q30);
    m2_phi  <= 46'(m1_mag[33:17]) * 46'(stsf_pkg::LOG10_OF_2_Q30);
    m2_neg  <= m1_neg;
    m2_sent <= m1_sent;
    m2_code <= m1_code;
    m3_code <= m2_code;
    if (m2_sent) begin
      m3_lv <= SENTINEL_L;
    end else if (m2_neg) begin
      m3_lv <= -signed'(l10_mag);
    end else begin
      m3_lv <= signed'(l10_mag);
    end
  end

  // ---------------- cutoff tests and t = n / d ----------------
  logic signed [DW-1:0] n_s, d_s;
  stsf_pkg::tp_code_t   cmp_code;

  always_comb begin
    n_s = DW'(m3_lv) - DW'(lower_cutoff);
    d_s = DW'(upper_cutoff) - DW'(lower_cutoff);
    if (m3_code == stsf_pkg::TP_FULL) begin
      cmp_code = stsf_pkg::TP_FULL;
    end else if (m3_lv < lower_cutoff) begin
      cmp_code = stsf_pkg::TP_ZERO;
    end else if (m3_lv > upper_cutoff) begin
      cmp_code = stsf_pkg::TP_FULL;
    end else if (d_s == 0 || n_s >= d_s || curve_power == 0) begin
      cmp_code = stsf_pkg::TP_FULL;
    end else if (n_s == 0) begin
      cmp_code = stsf_pkg::TP_ZERO;
    end else begin
      cmp_code = stsf_pkg::TP_CALC;
    end
  end

  logic               dv_valid [0:WB];
  logic [DW-1:0]      dv_rem   [0:WB];
  logic [WB-1:0]      dv_t     [0:WB];
  stsf_pkg::tp_code_t dv_code  [0:WB];
  logic [DW-1:0]      dv_d;

  // band width; user keeps registers static while requests are in flight, unenforced
  assign dv_d = unsigned'(d_s);

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else begin
      dv_valid[0] <= m3_valid;
    end
    dv_rem[0]  <= unsigned'(n_s);
    dv_t[0]    <= '0;
    dv_code[0] <= cmp_code;
  end

  // restoring divider, one quotient bit per stage
  for (genvar i = 0; i < WB; i++) begin : g_div
    logic [DW:0] rs;
    logic        ge;
    assign rs = {dv_rem[i], 1'b0};
    assign ge = rs >= {1'b0, dv_d};
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[i+1] <= 1'b0;
      end else begin
        dv_valid[i+1] <= dv_valid[i];
      end
      dv_rem[i+1]  <= ge ? DW'(rs - {1'b0, dv_d}) : DW'(rs);
      dv_t[i+1]    <= {dv_t[i][WB-2:0], ge};
      dv_code[i+1] <= dv_code[i];
    end
  end

  // ---------------- normalize t = 2^-k * 1.x ----------------
  logic               nm_valid [0:NORM_STEPS];
  logic [30:0]        nm_w     [0:NORM_STEPS];
  logic [4:0]         nm_k     [0:NORM_STEPS];
  stsf_pkg::tp_code_t nm_code  [0:NORM_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      nm_valid[0] <= 1'b0;
    end else begin
      nm_valid[0] <= dv_valid[WB];
    end
    nm_w[0] <= {1'b0, dv_t[WB]};
    nm_k[0] <= '0;
    nm_code[0] <= (dv_code[WB] == stsf_pkg::TP_CALC && dv_t[WB] == '0) ?
                  stsf_pkg::TP_ZERO : dv_code[WB];
  end

  for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
    localparam int S = 16 >> j;
    logic hit;
    assign hit = (nm_w[j][30 -: S] == '0);
    always_ff @(posedge clk) begin
      if (rst) begin
        nm_valid[j+1] <= 1'b0;
      end else begin
        nm_valid[j+1] <= nm_valid[j];
      end
      nm_w[j+1]    <= hit ? (nm_w[j] << S) : nm_w[j];
      nm_k[j+1]    <= hit ? 5'(nm_k[j] + 5'(S)) : nm_k[j];
      nm_code[j+1] <= nm_code[j];
    end
  end

  // ---------------- second log2: mantissa of t ----------------
  logic               l2_valid [0:LG];
  logic [30:0]        l2_x     [0:LG];
  logic [LG-1:0]      l2_fr    [0:LG];
  logic [4:0]         l2_k     [0:LG];
  stsf_pkg::tp_code_t l2_code  [0:LG];

  always_ff @(posedge clk) begin
    if (rst) begin
      l2_valid[0] <= 1'b0;
    end else begin
      l2_valid[0] <= nm_valid[NORM_STEPS];
    end
    l2_x[0]    <= nm_w[NORM_STEPS];
    l2_fr[0]   <= '0;
    l2_k[0]    <= nm_k[NORM_STEPS];
    l2_code[0] <= nm_code[NORM_STEPS];
  end

  for (genvar i = 0; i < LG; i++) begin : g_lg2
    logic [31:0] step;
    assign step = stsf_pkg::lg_step(l2_x[i]);
    always_ff @(posedge clk) begin
      if (rst) begin
        l2_valid[i+1] <= 1'b0;
      end else begin
        l2_valid[i+1] <= l2_valid[i];
      end
      l2_x[i+1]    <= step[30:0];
      l2_fr[i+1]   <= l2_fr[i] | (LG'(step[31]) << (LG - 1 - i));
      l2_k[i+1]    <= l2_k[i];
      l2_code[i+1] <= l2_code[i];
    end
  end

  // ---------------- |log2 t| * p ----------------
  logic               q1_valid, q2_valid;
  logic [30:0]        q1_mag;
  logic [46:0]        q2_q;
  stsf_pkg::tp_code_t q1_code, q2_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      q1_valid <= 1'b0;
      q2_valid <= 1'b0;
    end else begin
      q1_valid <= l2_valid[LG];
      q2_valid <= q1_valid;
    end
    q1_mag  <= {l2_k[LG], LG'(0)} - 31'(l2_fr[LG]);
    q1_code <= l2_code[LG];
    q2_q    <= 47'(q1_mag) * 47'(curve_power);
    q2_code <= q1_code;
  end

  // ---------------- exp2 of the fraction, one root per stage ----------------
  logic               ex_valid [0:LG];
  logic [30:0]        ex_acc   [0:LG];
  logic [LG-1:0]      ex_f     [0:LG];
  logic [4:0]         ex_ip    [0:LG];
  stsf_pkg::tp_code_t ex_code  [0:LG];

  logic [8:0] q_ip;
  assign q_ip = q2_q[46:38];

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid[0] <= 1'b0;
    end else begin
      ex_valid[0] <= q2_valid;
    end
    ex_acc[0]  <= ONE_W;
    ex_f[0]    <= q2_q[37:12];
    ex_ip[0]   <= q_ip[4:0];
    ex_code[0] <= (q2_code == stsf_pkg::TP_CALC && q_ip >= 9'(stsf_pkg::IP_LIMIT)) ?
                  stsf_pkg::TP_ZERO : q2_code;
  end

  for (genvar i = 0; i < LG; i++) begin : g_exp
    localparam logic [29:0] ROOT = stsf_pkg::exp_root(i + 1);
    logic [60:0] prod;
    assign prod = 61'(ex_acc[i]) * 61'(ROOT);
    always_ff @(posedge clk) begin
      if (rst) begin
        ex_valid[i+1] <= 1'b0;
      end else begin
        ex_valid[i+1] <= ex_valid[i];
      end
      ex_acc[i+1]  <= ex_f[i][LG-1-i] ? prod[60:30] : ex_acc[i];
      ex_f[i+1]    <= ex_f[i];
      ex_ip[i+1]   <= ex_ip[i];
      ex_code[i+1] <= ex_code[i];
    end
  end

  // ---------------- t^p select, blend, round ----------------
  logic               tp_valid, bl_valid;
  logic [30:0]        tp_val;
  logic [RAT_W+30:0]  bl_prod;
  logic               bl_up;
  logic [RAT_W+30:0]  bl_round;
  logic [RAT_W-1:0]   bl_adj;

  always_ff @(posedge clk) begin
    if (rst) begin
      tp_valid <= 1'b0;
      bl_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      tp_valid <= ex_valid[LG];
      bl_valid <= tp_valid;
      done     <= bl_valid;
    end
    case (ex_code[LG])
      stsf_pkg::TP_FULL: tp_val <= ONE_W;
      stsf_pkg::TP_ZERO: tp_val <= '0;
      default:           tp_val <= ex_acc[LG] >> ex_ip[LG];
    endcase
    bl_up   <= step_ratio >= ONE_R;
    bl_prod <= (RAT_W + 31)'(step_ratio >= ONE_R ? step_ratio - ONE_R : ONE_R - step_ratio)
               * (RAT_W + 31)'(tp_val);
    step_factor <= bl_up ? RAT_W'(ONE_R + bl_adj) : RAT_W'(ONE_R - bl_adj);
  end

  always_comb begin
    bl_round = bl_prod + ((RAT_W + 31)'(1) << (WB - 1));
    bl_adj   = RAT_W'(bl_round >> WB);
  end

  // ---------------- checks ----------------
  logic nm_calc;
  assign nm_calc = nm_valid[NORM_STEPS] && nm_code[NORM_STEPS] == stsf_pkg::TP_CALC;

  `STSF_ASSERT_LAT(a_latency, clk, rst, start && !busy, LATENCY, done)
  `STSF_ASSERT_IMP(a_tp_bound, clk, rst, tp_valid, tp_val <= ONE_W)
  `STSF_ASSERT_IMP(a_norm_msb, clk, rst, nm_calc, nm_w[NORM_STEPS][30])
  `STSF_ASSERT_IMP(a_log_range, clk, rst, l1_valid[LG], l1_x[LG][30])

endmodule
